// ===== sv/pvp_pkg.sv =====
// ----------------------------------------------------------------------------
// Perspective vertex projector package
// Shared widths, codes and types for the projector pipeline.
// ----------------------------------------------------------------------------
package pvp_pkg;

    // Field widths.
    localparam int VW  = 20;          // input coordinate
    localparam int PW  = VW + 1;      // coordinate after origin shift
    localparam int KW  = 16;          // sine and cosine
    localparam int PRW = PW + KW;     // coordinate times trig value
    localparam int TW  = PRW + 1;     // sum of two such products
    localparam int MW  = TW + KW;     // eye term times trig value
    localparam int FRAC = 14;         // trig fraction bits
    localparam int EW  = MW + 1;      // wide eye-space sums
    localparam int DW  = EW - FRAC;   // floored eye-space y and depth
    localparam int NW  = DW + KW + 1; // scaled numerator
    localparam int QB  = 18;          // quotient bits kept before saturation
    localparam int OW  = 16;          // screen coordinate
    localparam int CW  = 12;          // screen centre
    localparam int EYW = 19;          // eye distance
    localparam int EYE_SHIFT = 28;    // Q7.12 to eye-space depth scale
    localparam int SW  = QB + 3;      // centre plus signed quotient
    localparam int CFG_IW = 3;        // register index width
    localparam int CFG_DW = EYW;      // widest register

    localparam logic signed [PW-1:0] ORIGIN_SHIFT = -21'sd2048;

    localparam logic signed [SW-1:0] SAT_MAX = SW'(32767);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(32768);

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEPTH = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Register indexes.
    localparam logic [CFG_IW-1:0] REG_SIN_THETA = 3'd0;
    localparam logic [CFG_IW-1:0] REG_COS_THETA = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SIN_PHI   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_COS_PHI   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_EYE_DIST  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SCALE     = 3'd5;
    localparam logic [CFG_IW-1:0] REG_CENTER_X  = 3'd6;
    localparam logic [CFG_IW-1:0] REG_CENTER_Y  = 3'd7;

    typedef struct packed {
        logic signed [KW-1:0] sin_theta;
        logic signed [KW-1:0] cos_theta;
        logic signed [KW-1:0] sin_phi;
        logic signed [KW-1:0] cos_phi;
        logic [EYW-1:0]       eye_distance;
        logic [KW-1:0]        proj_scale;
        logic [CW-1:0]        center_x;
        logic [CW-1:0]        center_y;
    } pvp_cfg_t;

    // Side information that travels with an item through the divider.
    typedef struct packed {
        logic bad;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } pvp_tag_t;

endpackage

// ===== sv/pvp_rotate.sv =====
// ----------------------------------------------------------------------------
// Eye-space rotation
// Five-stage pipeline: origin shift, two rotations and the depth offset.
// ----------------------------------------------------------------------------
module pvp_rotate
    import pvp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  pvp_cfg_t             cfg,
    input  logic                 in_vld,
    input  logic [VW-1:0]        vx,
    input  logic [VW-1:0]        vy,
    input  logic [VW-1:0]        vz,
    output logic                 out_vld,
    output logic signed [TW-1:0] xe,
    output logic signed [DW-1:0] ye,
    output logic signed [DW-1:0] ze
);

    logic [4:0] vld_reg;

    logic signed [PW-1:0]  a_x_reg, a_y_reg, a_z_reg;
    logic signed [PRW-1:0] b_xc_reg, b_ys_reg, b_xs_reg, b_yc_reg;
    logic signed [PW-1:0]  b_z_reg;
    logic signed [TW-1:0]  c_t_reg, c_xe_reg;
    logic signed [PW-1:0]  c_z_reg;
    logic signed [MW-1:0]  d_tc_reg, d_ts_reg;
    logic signed [PRW-1:0] d_zc_reg, d_zs_reg;
    logic signed [TW-1:0]  d_xe_reg, e_xe_reg;
    logic signed [DW-1:0]  e_ye_reg, e_ze_reg;

    logic signed [EW-1:0]  eye_term;
    logic signed [EW-1:0]  ye_wide;
    logic signed [EW-1:0]  ze_wide;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    // Depth offset in the same scale as the wide eye-space sums.
    assign eye_term = $signed({{(EW - EYW - EYE_SHIFT){1'b0}}, cfg.eye_distance,
                               {EYE_SHIFT{1'b0}}});

    // Second rotation sums before the floor to the narrower format.
    assign ye_wide = EW'(d_tc_reg) + (EW'(d_zs_reg) <<< FRAC);
    assign ze_wide = EW'(d_ts_reg) - (EW'(d_zc_reg) <<< FRAC) + eye_term;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage A: origin shift.
            a_x_reg <= $signed({vx[VW-1], vx}) + ORIGIN_SHIFT;
            a_y_reg <= $signed({vy[VW-1], vy}) + ORIGIN_SHIFT;
            a_z_reg <= $signed({vz[VW-1], vz}) + ORIGIN_SHIFT;

            // Stage B: first rotation products.
            b_xc_reg <= a_x_reg * $signed(cfg.cos_theta);
            b_ys_reg <= a_y_reg * $signed(cfg.sin_theta);
            b_xs_reg <= a_x_reg * $signed(cfg.sin_theta);
            b_yc_reg <= a_y_reg * $signed(cfg.cos_theta);
            b_z_reg  <= a_z_reg;

            // Stage C: first rotation sums.
            c_t_reg  <= -TW'(b_xc_reg) - TW'(b_ys_reg);
            c_xe_reg <= TW'(b_yc_reg) - TW'(b_xs_reg);
            c_z_reg  <= b_z_reg;

            // Stage D: second rotation products.
            d_tc_reg <= c_t_reg * $signed(cfg.cos_phi);
            d_ts_reg <= c_t_reg * $signed(cfg.sin_phi);
            d_zc_reg <= c_z_reg * $signed(cfg.cos_phi);
            d_zs_reg <= c_z_reg * $signed(cfg.sin_phi);
            d_xe_reg <= c_xe_reg;

            // Stage E: sums, floored by an arithmetic shift.
            e_ye_reg <= ye_wide[EW-1:FRAC];
            e_ze_reg <= ze_wide[EW-1:FRAC];
            e_xe_reg <= d_xe_reg;
        end
    end

    assign out_vld = vld_reg[4];
    assign xe      = e_xe_reg;
    assign ye      = e_ye_reg;
    assign ze      = e_ze_reg;

endmodule

// ===== sv/pvp_div.sv =====
// ----------------------------------------------------------------------------
// Two-lane pipelined divider
// Overflow check followed by one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module pvp_div
    import pvp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [NW-1:0]   num_x,
    input  logic [NW-1:0]   num_y,
    input  logic [DW-2:0]   den,
    input  pvp_tag_t        in_tag,
    output logic            out_vld,
    output logic [QB-1:0]   quo_x,
    output logic [QB-1:0]   quo_y,
    output pvp_tag_t        out_tag
);

    logic [QB:0]   vld_reg;
    logic [NW-1:0] rx_reg  [QB+1];
    logic [NW-1:0] ry_reg  [QB+1];
    logic [QB-1:0] qx_reg  [QB+1];
    logic [QB-1:0] qy_reg  [QB+1];
    logic [DW-2:0] den_reg [QB+1];
    pvp_tag_t      tag_reg [QB+1];

    logic [NW-1:0] den_top;
    pvp_tag_t      tag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-1:0], in_vld};
        end
    end

    // A quotient that needs more than QB bits saturates in any case.
    assign den_top = {den, {QB{1'b0}}};

    always_comb
    begin
        tag_next       = in_tag;
        tag_next.ovf_x = (num_x >= den_top);
        tag_next.ovf_y = (num_y >= den_top);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]  <= num_x;
            ry_reg[0]  <= num_y;
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            den_reg[0] <= den;
            tag_reg[0] <= tag_next;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [NW-1:0] dsh;
        logic          ge_x;
        logic          ge_y;

        assign dsh  = NW'(den_reg[k-1]) << (QB - k);
        assign ge_x = (rx_reg[k-1] >= dsh);
        assign ge_y = (ry_reg[k-1] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k]  <= ge_x ? rx_reg[k-1] - dsh : rx_reg[k-1];
                ry_reg[k]  <= ge_y ? ry_reg[k-1] - dsh : ry_reg[k-1];
                qx_reg[k]  <= {qx_reg[k-1][QB-2:0], ge_x};
                qy_reg[k]  <= {qy_reg[k-1][QB-2:0], ge_y};
                den_reg[k] <= den_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_vld = vld_reg[QB];
    assign quo_x   = qx_reg[QB];
    assign quo_y   = qy_reg[QB];
    assign out_tag = tag_reg[QB];

endmodule

// ===== sv/perspective_vertex_projector_core.sv =====
// ----------------------------------------------------------------------------
// Perspective vertex projector
// Rotates a vertex into eye space, divides by depth and maps it to pixels.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (low bit first)          tlast  tuser
//  s_axis    in         vx[19:0] vy[39:20] vz[59:40] pad      -      -
//  m_axis    out        screen_x[15:0] screen_y[31:16]        -      -
//                       status[33:32] pad
//  cfg       in         cfg_wen, cfg_index[2:0], cfg_data[18:0]
//
// One item is accepted per cycle unless the pipeline holds. The stages are
// five rotation, scale, magnitude, overflow check, 18 divider and output.
// The 18-stage restoring divider sets the depth of the pipeline.
// Reset clears all valid bits and loads the register defaults.
// When the output item is not taken, the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module perspective_vertex_projector_core
    import pvp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // vx, vy, vz, zero pad
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // screen_x, screen_y, status, zero pad
    input  logic              cfg_wen,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    pvp_cfg_t cfg_reg;
    logic     en;

    logic                 rot_vld;
    logic signed [TW-1:0] rot_xe;
    logic signed [DW-1:0] rot_ye;
    logic signed [DW-1:0] rot_ze;

    logic                 f_vld_reg;
    logic signed [NW-1:0] f_nx_reg, f_ny_reg;
    logic signed [DW-1:0] f_ze_reg;
    logic                 f_bad_reg;

    logic                 g_vld_reg;
    logic [NW-1:0]        g_mx_reg, g_my_reg;
    logic [DW-2:0]        g_den_reg;
    pvp_tag_t             g_tag_reg;
    pvp_tag_t             g_tag_next;

    logic                 div_vld;
    logic [QB-1:0]        div_qx, div_qy;
    pvp_tag_t             div_tag;

    logic signed [SW-1:0] qx_s, qy_s, sx_sum, sy_sum;
    logic signed [OW-1:0] sx_next, sy_next;
    logic [1:0]           st_next;
    logic                 sat_x, sat_y;

    logic                 out_vld_reg;
    logic signed [OW-1:0] sx_reg, sy_reg;
    logic [1:0]           st_reg;

    // Whole pipeline advances unless a finished item waits at the output.
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sin_theta    <= '0;
            cfg_reg.cos_theta    <= KW'(16384);
            cfg_reg.sin_phi      <= '0;
            cfg_reg.cos_phi      <= KW'(16384);
            cfg_reg.eye_distance <= EYW'(40960);
            cfg_reg.proj_scale   <= KW'(960);
            cfg_reg.center_x     <= CW'(160);
            cfg_reg.center_y     <= CW'(120);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_SIN_THETA: cfg_reg.sin_theta    <= cfg_data[KW-1:0];
                REG_COS_THETA: cfg_reg.cos_theta    <= cfg_data[KW-1:0];
                REG_SIN_PHI:   cfg_reg.sin_phi      <= cfg_data[KW-1:0];
                REG_COS_PHI:   cfg_reg.cos_phi      <= cfg_data[KW-1:0];
                REG_EYE_DIST:  cfg_reg.eye_distance <= cfg_data[EYW-1:0];
                REG_SCALE:     cfg_reg.proj_scale   <= cfg_data[KW-1:0];
                REG_CENTER_X:  cfg_reg.center_x     <= cfg_data[CW-1:0];
                REG_CENTER_Y:  cfg_reg.center_y     <= cfg_data[CW-1:0];
            endcase
        end
    end

    pvp_rotate u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg_reg),
        .in_vld  (s_tvalid),
        .vx      (s_tdata[VW-1:0]),
        .vy      (s_tdata[2*VW-1:VW]),
        .vz      (s_tdata[3*VW-1:2*VW]),
        .out_vld (rot_vld),
        .xe      (rot_xe),
        .ye      (rot_ye),
        .ze      (rot_ze)
    );

    // Valid bits of the scale and magnitude stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= rot_vld;
            g_vld_reg <= f_vld_reg;
        end
    end

    always_comb
    begin
        g_tag_next       = '0;
        g_tag_next.bad   = f_bad_reg;
        g_tag_next.neg_x = f_nx_reg[NW-1];
        g_tag_next.neg_y = f_ny_reg[NW-1];
    end

    // Scale by the projection factor, then split into sign and magnitude.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_nx_reg  <= $signed({1'b0, cfg_reg.proj_scale}) * rot_xe;
            f_ny_reg  <= $signed({1'b0, cfg_reg.proj_scale}) * rot_ye;
            f_ze_reg  <= rot_ze;
            f_bad_reg <= rot_ze[DW-1] || (rot_ze == '0);

            g_mx_reg  <= f_nx_reg[NW-1] ? NW'(-f_nx_reg) : NW'(f_nx_reg);
            g_my_reg  <= f_ny_reg[NW-1] ? NW'(-f_ny_reg) : NW'(f_ny_reg);
            g_den_reg <= f_ze_reg[DW-2:0];
            g_tag_reg <= g_tag_next;
        end
    end

    pvp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (g_vld_reg),
        .num_x   (g_mx_reg),
        .num_y   (g_my_reg),
        .den     (g_den_reg),
        .in_tag  (g_tag_reg),
        .out_vld (div_vld),
        .quo_x   (div_qx),
        .quo_y   (div_qy),
        .out_tag (div_tag)
    );

    // Restore sign, add the screen centre and saturate.
    always_comb
    begin
        qx_s   = div_tag.neg_x ? -SW'({1'b0, div_qx}) : SW'({1'b0, div_qx});
        qy_s   = div_tag.neg_y ? -SW'({1'b0, div_qy}) : SW'({1'b0, div_qy});
        sx_sum = SW'({1'b0, cfg_reg.center_x}) + qx_s;
        sy_sum = SW'({1'b0, cfg_reg.center_y}) - qy_s;
        sat_x  = 1'b1;
        sat_y  = 1'b1;

        priority if (div_tag.ovf_x)
            sx_next = div_tag.neg_x ? OW'(SAT_MIN) : OW'(SAT_MAX);
        else if (sx_sum > SAT_MAX)
            sx_next = OW'(SAT_MAX);
        else if (sx_sum < SAT_MIN)
            sx_next = OW'(SAT_MIN);
        else
        begin
            sx_next = sx_sum[OW-1:0];
            sat_x   = 1'b0;
        end

        priority if (div_tag.ovf_y)
            sy_next = div_tag.neg_y ? OW'(SAT_MAX) : OW'(SAT_MIN);
        else if (sy_sum > SAT_MAX)
            sy_next = OW'(SAT_MAX);
        else if (sy_sum < SAT_MIN)
            sy_next = OW'(SAT_MIN);
        else
        begin
            sy_next = sy_sum[OW-1:0];
            sat_y   = 1'b0;
        end

        // Depth not positive overrides everything.
        if (div_tag.bad)
        begin
            sx_next = '0;
            sy_next = '0;
            st_next = ST_DEPTH;
        end
        else
        begin
            st_next = (sat_x || sat_y) ? ST_SAT : ST_OK;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            st_reg <= st_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, st_reg, sy_reg, sx_reg};

    // A depth error always carries a zero position.
    a_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st_reg == ST_DEPTH) |-> (sx_reg == '0 && sy_reg == '0))
        else $error("depth error item with nonzero position");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st_reg == ST_OK || st_reg == ST_DEPTH || st_reg == ST_SAT))
        else $error("undefined status code");

    // A new output item appears only after the pipeline advanced.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(en))
        else $error("output valid rose during a stall");

    // A saturated item has a coordinate at a clamp limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st_reg == ST_SAT) |->
            (sx_reg == OW'(SAT_MAX) || sx_reg == OW'(SAT_MIN) ||
             sy_reg == OW'(SAT_MAX) || sy_reg == OW'(SAT_MIN)))
        else $error("saturation status without a clamped coordinate");

endmodule
